// ----- hw/rtl/tgss_pkg.sv -----
// shared types and constants of the timed gas sample sequencer
// used by tgss_ctrl, tgss_dp, the top level and the checker; no dependencies
package tgss_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned ValW  = 15;
  localparam int unsigned SumW  = 23;
  localparam int unsigned CntW  = 8;
  localparam int unsigned GapW  = 16;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned CfgAw = 3;
  localparam int unsigned DivCntW = 5;
  localparam logic [DivCntW-1:0] DivSteps = DivCntW'(SumW);

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 32;

  // register indexes
  localparam logic [CfgAw-1:0] CFG_WARMUP  = 3'd0;
  localparam logic [CfgAw-1:0] CFG_INTERVAL = 3'd1;
  localparam logic [CfgAw-1:0] CFG_FLUSH   = 3'd2;
  localparam logic [CfgAw-1:0] CFG_SETTLE  = 3'd3;
  localparam logic [CfgAw-1:0] CFG_GAP     = 3'd4;
  localparam logic [CfgAw-1:0] CFG_SAMPLES = 3'd5;
  localparam logic [CfgAw-1:0] CFG_FRESH   = 3'd6;
  localparam logic [CfgAw-1:0] CFG_BACKOFF = 3'd7;

  // register reset values
  localparam logic [TimeW-1:0] WarmupRst   = 32'd300000;
  localparam logic [TimeW-1:0] IntervalRst = 32'd60000;
  localparam logic [TimeW-1:0] FlushRst    = 32'd3000;
  localparam logic [TimeW-1:0] SettleRst   = 32'd1000;
  localparam logic [GapW-1:0]  GapRst      = 16'd250;
  localparam logic [CntW-1:0]  SamplesRst  = 8'd10;
  localparam logic [TimeW-1:0] FreshRst    = 32'd15000;
  localparam logic [TimeW-1:0] BackoffRst  = 32'd1000;

  typedef enum logic [2:0] {
    PH_UNINIT  = 3'd0,
    PH_WARMUP  = 3'd1,
    PH_WAITING = 3'd2,
    PH_FLUSH   = 3'd3,
    PH_SETTLE  = 3'd4,
    PH_SAMPLE  = 3'd5,
    PH_GAP     = 3'd6,
    PH_BACKOFF = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NOSTART  = 3'd1,
    ERR_ZEROCNT  = 3'd2,
    ERR_INITFAIL = 3'd3,
    ERR_READFAIL = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    FN_TICK    = 2'd0,
    FN_START   = 2'd1,
    FN_REQUEST = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_UPDATE,
    ST_DIV,
    ST_RESULT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic calc;
    logic update;
    logic div_run;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_req;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/tgss_ctrl.sv -----
// sequencing state machine of the timed gas sample sequencer
// depends on tgss_pkg; drives the command struct of tgss_dp
module tgss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tgss_pkg::status_t status_i,
  output tgss_pkg::cmd_t    cmd_o
);
  import tgss_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CALC;
      ST_CALC:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = status_i.div_req ? ST_DIV : ST_RESULT;
      ST_DIV:    if (status_i.div_last) state_d = ST_RESULT;
      ST_RESULT: if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_CALC:   cmd_o.calc     = 1'b1;
      ST_UPDATE: cmd_o.update   = 1'b1;
      ST_DIV:    cmd_o.div_run  = 1'b1;
      ST_RESULT: cmd_o.out_load = status_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/tgss_dp.sv -----
// datapath of the timed gas sample sequencer: settings, sequencer state,
// time compares, bit-serial divider and output register; depends on tgss_pkg
module tgss_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tgss_pkg::CfgAw-1:0]       cfg_addr_i,
  input  logic [tgss_pkg::CfgW-1:0]        cfg_data_i,
  input  logic [1:0]                       in_user_i,
  input  logic [tgss_pkg::InDataW-1:0]     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tgss_pkg::OutDataW-1:0]    out_data_o,
  input  tgss_pkg::cmd_t                   cmd_i,
  output tgss_pkg::status_t                status_o
);
  import tgss_pkg::*;

  // settings
  logic [TimeW-1:0] warmup_q, interval_q, flush_q, settle_q, fresh_q, backoff_q;
  logic [GapW-1:0]  gap_q;
  logic [CntW-1:0]  samples_q;

  // captured item
  func_e            func_q;
  logic [TimeW-1:0] now_q;
  logic             init_ok_q, sample_ok_q;
  logic [ValW-1:0]  value_q;

  // time compares
  logic expired_q, due_q, stale_q;

  // sequencer state
  phase_e           phase_q, phase_d;
  logic [TimeW-1:0] ph_start_q, ph_start_d, ph_len_q, ph_len_d;
  logic             valid_q, valid_d, early_q, early_d, valve_q, valve_d;
  logic             started_q, started_d;
  logic [TimeW-1:0] last_done_q, last_done_d;
  logic [ValW-1:0]  avg_q, avg_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  err_e             err_q, err_d;

  // divider
  logic [CntW-1:0]    rem_q, rem_d, den_q, den_d;
  logic [SumW-1:0]    quo_q, quo_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic [CntW:0]      shifted, trial;
  logic               qbit;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic [SumW-1:0]  sum_inc;
  logic [CntW-1:0]  cnt_inc;
  logic             cycle_done, need_div;
  logic [TimeW-1:0] age_now, age_ph, age_done;
  logic             fresh_now, busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warmup_q   <= WarmupRst;
      interval_q <= IntervalRst;
      flush_q    <= FlushRst;
      settle_q   <= SettleRst;
      gap_q      <= GapRst;
      samples_q  <= SamplesRst;
      fresh_q    <= FreshRst;
      backoff_q  <= BackoffRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_WARMUP:   warmup_q   <= cfg_data_i;
        CFG_INTERVAL: interval_q <= cfg_data_i;
        CFG_FLUSH:    flush_q    <= cfg_data_i;
        CFG_SETTLE:   settle_q   <= cfg_data_i;
        CFG_GAP:      gap_q      <= cfg_data_i[GapW-1:0];
        CFG_SAMPLES:  samples_q  <= cfg_data_i[CntW-1:0];
        CFG_FRESH:    fresh_q    <= cfg_data_i;
        CFG_BACKOFF:  backoff_q  <= cfg_data_i;
        default:      warmup_q   <= warmup_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q      <= func_e'(in_user_i);
      now_q       <= in_data_i[TimeW-1:0];
      init_ok_q   <= in_data_i[TimeW];
      sample_ok_q <= in_data_i[TimeW+1];
      value_q     <= in_data_i[TimeW+2 +: ValW];
    end
  end

  assign age_ph   = now_q - ph_start_q;
  assign age_done = now_q - last_done_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      expired_q <= (age_ph >= ph_len_q);
      due_q     <= (age_done >= interval_q);
      stale_q   <= !(valid_q && (age_done <= fresh_q));
    end
  end

  assign sum_inc    = sum_q + SumW'(value_q);
  assign cnt_inc    = cnt_q + 1'b1;
  assign cycle_done = (cnt_inc == '0) || (cnt_inc >= samples_q);
  assign need_div   = (func_q == FN_TICK) && (phase_q == PH_SAMPLE) && sample_ok_q
                      && cycle_done;

  // one quotient bit per cycle, restoring
  assign shifted = {rem_q, quo_q[SumW-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign qbit    = (shifted >= {1'b0, den_q});

  always_comb begin
    phase_d     = phase_q;
    ph_start_d  = ph_start_q;
    ph_len_d    = ph_len_q;
    valid_d     = valid_q;
    early_d     = early_q;
    valve_d     = valve_q;
    started_d   = started_q;
    last_done_d = last_done_q;
    avg_d       = avg_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    div_cnt_d   = div_cnt_q;
    if (cmd_i.update) begin
      started_d = 1'b0;
      case (func_q)
        FN_TICK: begin
          case (phase_q)
            PH_WARMUP, PH_BACKOFF: begin
              if (expired_q) begin
                phase_d    = PH_WAITING;
                ph_start_d = now_q;
                ph_len_d   = '0;
              end
            end
            PH_WAITING: begin
              if (early_q || !valid_q || due_q) begin
                early_d    = 1'b0;
                sum_d      = '0;
                cnt_d      = '0;
                valve_d    = 1'b1;
                phase_d    = PH_FLUSH;
                ph_start_d = now_q;
                ph_len_d   = flush_q;
              end
            end
            PH_FLUSH: begin
              if (expired_q) begin
                valve_d    = 1'b0;
                phase_d    = PH_SETTLE;
                ph_start_d = now_q;
                ph_len_d   = settle_q;
              end
            end
            PH_SETTLE: begin
              if (expired_q) begin
                sum_d      = '0;
                cnt_d      = '0;
                phase_d    = PH_SAMPLE;
                ph_start_d = now_q;
                ph_len_d   = '0;
              end
            end
            PH_SAMPLE: begin
              ph_start_d = now_q;
              if (!sample_ok_q) begin
                valve_d  = 1'b0;
                err_d    = ERR_READFAIL;
                phase_d  = PH_BACKOFF;
                ph_len_d = backoff_q;
              end else begin
                sum_d = sum_inc;
                cnt_d = cnt_inc;
                if (cycle_done) begin
                  valve_d     = 1'b0;
                  valid_d     = 1'b1;
                  last_done_d = now_q;
                  err_d       = ERR_NONE;
                  phase_d     = PH_WAITING;
                  ph_len_d    = '0;
                  // a wrapped count divides by one
                  rem_d       = '0;
                  quo_d       = sum_inc;
                  den_d       = (cnt_inc == '0) ? CntW'(1) : cnt_inc;
                  div_cnt_d   = DivSteps;
                end else begin
                  phase_d  = PH_GAP;
                  ph_len_d = TimeW'(gap_q);
                end
              end
            end
            PH_GAP: begin
              if (expired_q) begin
                phase_d    = PH_SAMPLE;
                ph_start_d = now_q;
                ph_len_d   = '0;
              end
            end
            default: phase_d = phase_q;
          endcase
        end
        FN_START: begin
          valve_d    = 1'b0;
          ph_start_d = now_q;
          if (samples_q == '0) begin
            err_d    = ERR_ZEROCNT;
            phase_d  = PH_UNINIT;
            ph_len_d = '0;
          end else if (!init_ok_q) begin
            err_d    = ERR_INITFAIL;
            phase_d  = PH_UNINIT;
            ph_len_d = '0;
          end else begin
            valid_d     = 1'b0;
            early_d     = 1'b0;
            last_done_d = '0;
            avg_d       = '0;
            sum_d       = '0;
            cnt_d       = '0;
            err_d       = ERR_NONE;
            phase_d     = PH_WARMUP;
            ph_len_d    = warmup_q;
            started_d   = 1'b1;
          end
        end
        FN_REQUEST: begin
          if (stale_q) early_d = 1'b1;
        end
        default: early_d = early_q;
      endcase
    end else if (cmd_i.div_run) begin
      rem_d     = qbit ? trial[CntW-1:0] : shifted[CntW-1:0];
      quo_d     = {quo_q[SumW-2:0], qbit};
      div_cnt_d = div_cnt_q - 1'b1;
      if (div_cnt_q == DivCntW'(1)) avg_d = quo_d[ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_UNINIT;
      ph_start_q  <= '0;
      ph_len_q    <= '0;
      valid_q     <= 1'b0;
      early_q     <= 1'b0;
      valve_q     <= 1'b0;
      started_q   <= 1'b0;
      last_done_q <= '0;
      avg_q       <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      err_q       <= ERR_NOSTART;
      div_cnt_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      ph_start_q  <= ph_start_d;
      ph_len_q    <= ph_len_d;
      valid_q     <= valid_d;
      early_q     <= early_d;
      valve_q     <= valve_d;
      started_q   <= started_d;
      last_done_q <= last_done_d;
      avg_q       <= avg_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  // result fields from the state after the item
  assign age_now   = now_q - last_done_q;
  assign fresh_now = valid_q && (age_now <= fresh_q);
  assign busy      = (phase_q == PH_FLUSH) || (phase_q == PH_SETTLE) ||
                     (phase_q == PH_SAMPLE) || (phase_q == PH_GAP);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {6'b0, err_q, busy, avg_q, fresh_now, valid_q, started_q,
                     valve_q, phase_q};
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign status_o.div_req  = need_div;
  assign status_o.div_last = (div_cnt_q == DivCntW'(1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ----- hw/rtl/timed_gas_sample_sequencer.sv -----
// top level of the timed gas sample sequencer
// instantiates tgss_ctrl and tgss_dp; depends on tgss_pkg
//
// channel   | direction | fields (lowest bit first)
// ----------+-----------+---------------------------------------------------------
// s_axis    | in        | tuser: func; tdata: now_ms, sensor_init_ok, sample_ok,
//           |           |        sample_value, zero fill to 56 bits
// m_axis    | out       | tdata: phase, valve_open, start_ok, value_valid,
//           |           |        value_fresh, average_value, busy_res, error_code,
//           |           |        zero fill to 32 bits
// cfg       | in        | cfg_we_i, cfg_addr_i (register index), cfg_data_i
//
// sequence: one item at a time; the item is captured, the time compares and the
// state update follow, then the bit-serial divider when the item completes an
// average (one quotient bit per cycle over the 23-bit sample sum), then the
// result is loaded; the input is ready again as the result becomes valid
// reset: asynchronous, active low; settings return to their defaults, the
// sequencer to uninitialised with error "not started"
// stalls: the result sits in an output register; the next item is taken while
// it waits, and its own result is held back until the register frees
module timed_gas_sample_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [tgss_pkg::CfgAw-1:0]    cfg_addr_i,
  input  logic [tgss_pkg::CfgW-1:0]     cfg_data_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [1:0]                    s_axis_tuser,  // func
  // now_ms, sensor_init_ok, sample_ok, sample_value, zero fill
  input  logic [tgss_pkg::InDataW-1:0]  s_axis_tdata,
  // results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // phase, valve_open, start_ok, value_valid, value_fresh, average_value,
  // busy_res, error_code, zero fill
  output logic [tgss_pkg::OutDataW-1:0] m_axis_tdata
);
  import tgss_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing: capture, time compares, state update, divide, result
  tgss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // settings, sequencer state, divider and output register
  tgss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ----- hw/rtl/tgss_checker.sv -----
// port-level checks of the timed gas sample sequencer, bound to the top level
// depends on tgss_pkg
module tgss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tgss_pkg::OutDataW-1:0] m_axis_tdata
);
  import tgss_pkg::*;

  logic [2:0] res_phase;
  logic       res_valve, res_start_ok;
  logic [2:0] res_err;

  assign res_phase    = m_axis_tdata[2:0];
  assign res_valve    = m_axis_tdata[3];
  assign res_start_ok = m_axis_tdata[4];
  assign res_err      = m_axis_tdata[25:23];

  // one item in flight: no second transfer straight after the first
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // valve only open while flushing
  a_valve_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_valve) |-> (res_phase == PH_FLUSH))
    else $error("valve open outside flush");

  // a successful start leaves warmup with no error
  a_start_warmup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_start_ok) |-> (res_phase == PH_WARMUP && res_err == ERR_NONE))
    else $error("start reported ok without warmup");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind timed_gas_sample_sequencer tgss_checker u_tgss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
